@@ rtl/tsrr_pkg.sv @@
// Package for the task slot round-robin scheduler: sizes, codes, row types and masks.
`default_nettype none
package tsrr_pkg;

   localparam int NUM_SLOTS     = 256;
   localparam int SLOTS_PER_ROW = (NUM_SLOTS >= 32) ? 32 : (2 ** $clog2(NUM_SLOTS));
   localparam int NUM_ROWS      = (NUM_SLOTS + SLOTS_PER_ROW - 1) / SLOTS_PER_ROW;
   localparam int COL_W         = $clog2(SLOTS_PER_ROW);
   localparam int ROW_W         = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int VISIT_W       = $clog2(NUM_ROWS + 1);
   localparam int ROW_DATA_W    = 2 * SLOTS_PER_ROW;
   localparam int SN_W          = ROW_W + COL_W;
   localparam int RES_W         = (SN_W > 8) ? SN_W : 8;
   localparam int ID_EXT_W      = ((SN_W > 8) ? SN_W : 8) + 1;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_SET     = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_SCHED   = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_NONE_READY = 2'd2;
   localparam logic [1:0] ST_BAD_ID     = 2'd3;

   localparam logic [1:0] RUN_READY = 2'd0;

   // row word: in-use bits low, ready bits high
   typedef struct packed {
      logic [1:0]       action;
      logic [1:0]       run_state;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             first_visit;
      logic             last_visit;
   } row_req_type;

   typedef struct packed {
      logic                  hit;
      logic [COL_W-1:0]      hit_col;
      logic                  wr_en;
      logic [ROW_DATA_W-1:0] wr_data;
   } row_rsp_type;

   // slots of a row that may ever be allocated: not slot 0, not beyond the table
   function automatic logic [SLOTS_PER_ROW-1:0] row_slot_mask(input logic [ROW_W-1:0] row);
      logic [SLOTS_PER_ROW-1:0] m;
      int s;
      for (int c = 0; c < SLOTS_PER_ROW; c++) begin
         s = int'(row) * SLOTS_PER_ROW + c;
         m[c] = (s != 0) && (s < NUM_SLOTS);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

@@ rtl/tsrr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tsrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/tsrr_row_logic.sv @@
// Per-row evaluation: free/ready/in-use search within one row word and its update.
`default_nettype none
module tsrr_row_logic
   import tsrr_pkg::*;
(
   input  wire row_req_type           req,
   input  wire logic [ROW_DATA_W-1:0] row_data,
   output row_rsp_type                rsp
);
   logic [SLOTS_PER_ROW-1:0] in_use;
   logic [SLOTS_PER_ROW-1:0] ready;
   logic [SLOTS_PER_ROW-1:0] above;
   logic [SLOTS_PER_ROW-1:0] sel;
   logic [SLOTS_PER_ROW-1:0] cand;
   logic [SLOTS_PER_ROW-1:0] hit_bit;
   logic [COL_W-1:0]         hit_col;

   assign in_use = row_data[SLOTS_PER_ROW-1:0];
   assign ready  = row_data[ROW_DATA_W-1:SLOTS_PER_ROW];

   always_comb begin
      for (int c = 0; c < SLOTS_PER_ROW; c++) begin
         above[c] = (c > int'(req.col));
      end
      if (req.first_visit) begin
         sel = above;
      end else if (req.last_visit) begin
         sel = ~above;
      end else begin
         sel = '1;
      end
   end

   always_comb begin
      unique case (req.action)
         ACT_ALLOC:   cand = ~in_use & row_slot_mask(req.row);
         ACT_SET,
         ACT_RELEASE: cand = in_use & (SLOTS_PER_ROW'(1) << req.col);
         ACT_SCHED:   cand = ready & sel;
         default:     cand = '0;
      endcase
   end

   always_comb begin
      hit_col = '0;
      for (int c = SLOTS_PER_ROW - 1; c >= 0; c--) begin
         if (cand[c]) begin
            hit_col = COL_W'(c);
         end
      end
   end

   assign hit_bit = SLOTS_PER_ROW'(1) << hit_col;

   always_comb begin
      rsp.hit     = |cand;
      rsp.hit_col = hit_col;
      rsp.wr_en   = (|cand) && (req.action != ACT_SCHED);
      rsp.wr_data = row_data;
      unique case (req.action)
         ACT_ALLOC: begin
            rsp.wr_data = {ready | hit_bit, in_use | hit_bit};
         end
         ACT_SET: begin
            if (req.run_state == RUN_READY) begin
               rsp.wr_data = {ready | hit_bit, in_use};
            end else begin
               rsp.wr_data = {ready & ~hit_bit, in_use};
            end
         end
         ACT_RELEASE: begin
            rsp.wr_data = {ready & ~hit_bit, in_use & ~hit_bit};
         end
         default: begin
            rsp.wr_data = row_data;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/task_slot_round_robin_scheduler.sv @@
// Top level: task slot table in a row RAM, sequencer for allocate, set, release, schedule.
//
//  channel  dir  handshake              tdata bits
//  req_     in   req_tvalid/req_tready  [1:0] action, [9:2] slot_id, [11:10] new_run_state
//  rsp_     out  rsp_tvalid/rsp_tready  [7:0] result_slot, [9:8] status
//
//  Slots sit 32 to a RAM row (in-use and ready bits); one row is read per cycle.
//  Set state, release: one row read and update; a bad slot id (slot 0) skips the read.
//  Allocate: scans rows upward from row 0 until a row with a free slot, or the last row.
//  Schedule: scans rows onward from the current slot's row, wrapping back to that row.
//  Synchronous reset; per-row valid flops make every row read as empty, no clear pass.
//  A new request is taken while a result waits; the sequencer stalls only on a full
//  result register.
`default_nettype none
module task_slot_round_robin_scheduler
   import tsrr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [1:0] action, [9:2] slot_id, [11:10] new_run_state
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // [7:0] result_slot, [9:8] status
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          action_ff, action_in;
   logic [1:0]          nrs_ff, nrs_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [VISIT_W-1:0]  visit_ff, visit_in;
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [NUM_ROWS-1:0] row_valid_ff, row_valid_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [SN_W-1:0]     res_ff, res_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;

   logic                  req_xfer;
   logic [1:0]            req_action;
   logic [ID_EXT_W-1:0]   req_id;
   logic                  req_bad;
   logic                  rd_en;
   logic [ROW_W-1:0]      rd_addr;
   logic [ROW_DATA_W-1:0] rd_data;
   logic [ROW_DATA_W-1:0] row_data;
   logic [ROW_W-1:0]      next_row;
   logic                  more;
   logic                  load_rsp;
   logic [RES_W-1:0]      res_wide;
   row_req_type           rl_req;
   row_rsp_type           rl_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_action = req_tdata[1:0];
   assign req_id     = ID_EXT_W'(req_tdata[9:2]);
   assign req_bad    = (req_id == '0) || (req_id >= ID_EXT_W'(NUM_SLOTS));

   assign row_data = rd_valid_ff ? rd_data : '0;
   assign next_row = (row_ff == ROW_W'(NUM_ROWS - 1)) ? '0 : row_ff + ROW_W'(1);

   assign rl_req.action      = action_ff;
   assign rl_req.run_state   = nrs_ff;
   assign rl_req.row         = row_ff;
   assign rl_req.col         = col_ff;
   assign rl_req.first_visit = (action_ff == ACT_SCHED) && (visit_ff == '0);
   assign rl_req.last_visit  = (action_ff == ACT_SCHED) && (visit_ff == VISIT_W'(NUM_ROWS));

   tsrr_row_logic u_row_logic (
      .req      (rl_req),
      .row_data (row_data),
      .rsp      (rl_rsp)
   );

   tsrr_ram #(
      .WIDTH (ROW_DATA_W),
      .DEPTH (NUM_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   ((state_ff == S_EVAL) && rl_rsp.wr_en),
      .wr_addr (row_ff),
      .wr_data (rl_rsp.wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (action_ff)
         ACT_ALLOC: more = !rl_rsp.hit && (row_ff != ROW_W'(NUM_ROWS - 1));
         ACT_SCHED: more = !rl_rsp.hit && (visit_ff != VISIT_W'(NUM_ROWS));
         default:   more = 1'b0;
      endcase
   end

   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      nrs_in       = nrs_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      visit_in     = visit_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      row_valid_in = row_valid_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rd_en        = 1'b0;
      rd_addr      = row_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               action_in = req_action;
               nrs_in    = req_tdata[11:10];
               visit_in  = '0;
               unique case (req_action)
                  ACT_ALLOC: begin
                     row_in = '0;
                     col_in = '0;
                  end
                  ACT_SET, ACT_RELEASE: begin
                     row_in = ROW_W'(req_id >> COL_W);
                     col_in = req_id[COL_W-1:0];
                  end
                  default: begin
                     row_in = cur_row_ff;
                     col_in = cur_col_ff;
                  end
               endcase
               if ((req_action == ACT_SET || req_action == ACT_RELEASE) && req_bad) begin
                  res_in    = '0;
                  status_in = ST_BAD_ID;
                  state_in  = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = row_in;
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            if (rl_rsp.wr_en) begin
               row_valid_in[row_ff] = 1'b1;
            end
            if (more) begin
               rd_en    = 1'b1;
               rd_addr  = next_row;
               row_in   = next_row;
               visit_in = visit_ff + VISIT_W'(1);
            end else begin
               state_in = S_DONE;
               res_in   = '0;
               if (rl_rsp.hit) begin
                  status_in = ST_OK;
                  if (action_ff == ACT_ALLOC || action_ff == ACT_SCHED) begin
                     res_in = {row_ff, rl_rsp.hit_col};
                  end
                  if (action_ff == ACT_SCHED) begin
                     cur_row_in = row_ff;
                     cur_col_in = rl_rsp.hit_col;
                  end
               end else begin
                  unique case (action_ff)
                     ACT_ALLOC: status_in = ST_FULL;
                     ACT_SCHED: status_in = ST_NONE_READY;
                     default:   status_in = ST_BAD_ID;
                  endcase
               end
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_valid_in = rd_en ? row_valid_ff[rd_addr] : rd_valid_ff;
   assign res_wide    = RES_W'(res_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, status_ff, res_wide[7:0]};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      nrs_ff      <= nrs_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      visit_ff    <= visit_in;
      rd_valid_ff <= rd_valid_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

@@ sim/task_slot_round_robin_scheduler_test.sv @@
// Testbench for the task slot round-robin scheduler: self-checking, with directed and random traffic.
module task_slot_round_robin_scheduler_test;
   import tsrr_pkg::*;

   localparam logic [1:0] RUN_WAIT  = 2'd1;
   localparam logic [1:0] RUN_EXIT  = 2'd2;
   localparam logic [1:0] RUN_OTHER = 2'd3;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 30;
   localparam int RANDOM_ITEMS  = 960;

   typedef struct packed {
      logic [7:0] slot;
      logic [1:0] status;
   } slot_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [1:0] action, [9:2] slot_id, [11:10] new_run_state
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [7:0] result_slot, [9:8] status

   logic       slot_busy [NUM_SLOTS];
   logic [1:0] slot_state [NUM_SLOTS];
   int         current_slot;

   slot_result_type pending_results [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  rsp_stall = 0;
   bit  req_gaps = 1'b0;
   bit  rsp_gaps = 1'b0;

   task_slot_round_robin_scheduler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit slot_ready(int s);
      return slot_busy[s] && slot_state[s] == RUN_READY;
   endfunction

   // applies one action to the slot table and returns the expected reply
   function automatic slot_result_type predict_slot_action(logic [1:0] action,
                                                           logic [7:0] id,
                                                           logic [1:0] run_state);
      slot_result_type r;
      int found;
      bit addressable;
      r.slot   = '0;
      r.status = ST_OK;
      found    = 0;
      addressable = id != 0 && int'(id) < NUM_SLOTS && slot_busy[id];
      case (action)
         ACT_ALLOC: begin
            r.status = ST_FULL;
            for (int s = 1; s < NUM_SLOTS; s++) begin
               if (found == 0 && !slot_busy[s]) found = s;
            end
            if (found != 0) begin
               slot_busy[found]  = 1'b1;
               slot_state[found] = RUN_READY;
               r.slot   = found[7:0];
               r.status = ST_OK;
            end
         end
         ACT_SET: begin
            if (addressable) slot_state[id] = run_state;
            else r.status = ST_BAD_ID;
         end
         ACT_RELEASE: begin
            if (addressable) slot_busy[id] = 1'b0;
            else r.status = ST_BAD_ID;
         end
         default: begin
            for (int s = current_slot + 1; s < NUM_SLOTS; s++) begin
               if (found == 0 && slot_ready(s)) found = s;
            end
            for (int s = 1; s <= current_slot && s < NUM_SLOTS; s++) begin
               if (found == 0 && slot_ready(s)) found = s;
            end
            if (found != 0) begin
               current_slot = found;
               r.slot = found[7:0];
            end else begin
               r.status = ST_NONE_READY;
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_action(logic [1:0] action, logic [7:0] id = '0,
                              logic [1:0] run_state = RUN_READY);
      int gap;
      gap = req_gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, run_state, id, action};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_slot_action(action, id, run_state));
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_busy_slot();
      int start;
      start = $urandom_range(1, NUM_SLOTS - 1);
      for (int k = 0; k < NUM_SLOTS - 1; k++) begin
         if (slot_busy[1 + (start - 1 + k) % (NUM_SLOTS - 1)])
            return 8'(1 + (start - 1 + k) % (NUM_SLOTS - 1));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps && !reset) begin
         rsp_stall  <= gap_length();
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= !reset;
      end
   end

   always @(posedge clock) begin
      slot_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer, actual slot %0d status %0d",
                     $time, rsp_tdata[7:0], rsp_tdata[9:8]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[7:0] !== want.slot) begin
               $display("%0t: result_slot expected %0d actual %0d",
                        $time, want.slot, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[9:8] !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_tdata[9:8]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reserved, free and never-written slots; nothing ready on an empty table
   task automatic test_empty_table();
      send_action(ACT_SCHED);
      send_action(ACT_SET, 8'd0, RUN_WAIT);
      send_action(ACT_RELEASE, 8'd255);
      send_action(ACT_SET, 8'hAA, RUN_OTHER);
      send_action(ACT_RELEASE, 8'h55);
      send_action(ACT_RELEASE, 8'd0);
      end_burst();
   endtask

   task automatic test_basic_ops();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      repeat (3) send_action(ACT_ALLOC);
      send_action(ACT_SCHED);
      send_action(ACT_SET, 8'd2, RUN_OTHER);
      send_action(ACT_SET, 8'd1, RUN_WAIT);
      send_action(ACT_SCHED);
      send_action(ACT_SET, 8'd3, RUN_EXIT);
      send_action(ACT_SCHED);
      send_action(ACT_SET, 8'd1, RUN_READY);
      send_action(ACT_SCHED);
      send_action(ACT_RELEASE, 8'd1);
      send_action(ACT_SCHED);
      send_action(ACT_SET, 8'd2, RUN_READY);
      send_action(ACT_SCHED);
      send_action(ACT_RELEASE, 8'd2);
      send_action(ACT_SET, 8'd1, RUN_READY);
      send_action(ACT_ALLOC);
      send_action(ACT_SCHED);
      end_burst();
   endtask

   // fill every slot, overflow, then free and reuse a middle slot and the top slot
   task automatic test_table_full();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      repeat (NUM_SLOTS) send_action(ACT_ALLOC);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      send_action(ACT_SCHED);
      send_action(ACT_SET, 8'd255, RUN_OTHER);
      send_action(ACT_SET, 8'd2, RUN_EXIT);
      send_action(ACT_RELEASE, 8'd128);
      send_action(ACT_ALLOC);
      send_action(ACT_ALLOC);
      repeat (4) send_action(ACT_SCHED);
      send_action(ACT_RELEASE, 8'd255);
      send_action(ACT_ALLOC);
      end_burst();
   endtask

   task automatic test_random_traffic();
      bit growing;
      int r;
      logic [1:0] action;
      logic [7:0] id;
      logic [1:0] run_state;
      growing = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            req_gaps = $urandom_range(0, 3) != 0;
            rsp_gaps = $urandom_range(0, 3) != 0;
         end
         if (n % 160 == 0) growing = !growing;
         r = $urandom_range(0, 99);
         if (growing)
            action = r < 45 ? ACT_ALLOC : r < 65 ? ACT_SET : r < 75 ? ACT_RELEASE : ACT_SCHED;
         else
            action = r < 10 ? ACT_ALLOC : r < 35 ? ACT_SET : r < 70 ? ACT_RELEASE : ACT_SCHED;
         id = $urandom_range(0, 9) < 8 ? pick_busy_slot() : 8'($urandom_range(0, 255));
         run_state = $urandom_range(0, 9) < 4 ? RUN_READY : 2'($urandom_range(0, 3));
         if (action != ACT_SET && action != ACT_RELEASE && $urandom_range(0, 1))
            id = 8'($urandom_range(0, 255));
         send_action(action, id, run_state);
      end
      end_burst();
   endtask

   initial begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         slot_busy[s]  = 1'b0;
         slot_state[s] = RUN_READY;
      end
      current_slot = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_basic_ops();
      test_table_full();
      test_random_traffic();
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
